### hdl/owtr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owtr_pkg
// Phase codes, command bytes, register indexes and scaling constants for the
// one-wire temperature reader.
// ----------------------------------------------------------------------------
package owtr_pkg;

    // One-hot sequencer phases
    typedef enum logic [9:0] {
        PH_IDLE   = 10'b00_0000_0001,
        PH_RST    = 10'b00_0000_0010,
        PH_PRES   = 10'b00_0000_0100,
        PH_GAP    = 10'b00_0000_1000,
        PH_WSTART = 10'b00_0001_0000,
        PH_WHOLD  = 10'b00_0010_0000,
        PH_WREC   = 10'b00_0100_0000,
        PH_RSTART = 10'b00_1000_0000,
        PH_RSAMP  = 10'b01_0000_0000,
        PH_RREC   = 10'b10_0000_0000
    } phase_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_RESET_LOW   = 3'd0,
        REG_PRES_TMO    = 3'd1,
        REG_GAP         = 3'd2,
        REG_START_LOW   = 3'd3,
        REG_WRITE_HOLD  = 3'd4,
        REG_READ_SAMPLE = 3'd5,
        REG_RECOVERY    = 3'd6,
        REG_TEMP_OFFSET = 3'd7
    } reg_index_t;

    // Bus command bytes
    localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
    localparam logic [7:0] CMD_CONVERT    = 8'h44;
    localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

    // Byte positions in the sequence
    localparam logic [2:0] BYTE_SECOND_RESET = 3'd2;
    localparam logic [2:0] BYTE_FIRST_READ   = 3'd4;
    localparam logic [2:0] BYTE_LAST_READ    = 3'd5;

    // raw * 6.25 hundredths of a degree, rounded half up: (raw*25 + 2) >> 2
    localparam logic [19:0] TEMP_MUL   = 20'd25;
    localparam logic [19:0] TEMP_ROUND = 20'd2;

    // Reset values of the registers
    localparam logic [15:0] RST_RESET_LOW   = 16'd480;
    localparam logic [15:0] RST_PRES_TMO    = 16'd5000;
    localparam logic [15:0] RST_GAP         = 16'd1000;
    localparam logic [15:0] RST_START_LOW   = 16'd1;
    localparam logic [15:0] RST_WRITE_HOLD  = 16'd68;
    localparam logic [15:0] RST_READ_SAMPLE = 16'd6;
    localparam logic [15:0] RST_RECOVERY    = 16'd48;
    localparam logic [11:0] RST_TEMP_OFFSET = 12'd750;

    // Command byte sent at a given byte position; read bytes start cleared
    function automatic logic [7:0] cmd_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = CMD_SKIP_ROM;
            3'd1:    b = CMD_CONVERT;
            3'd2:    b = CMD_SKIP_ROM;
            3'd3:    b = CMD_READ_SCRATCH;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

### hdl/one_wire_temperature_reader_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// one_wire_temperature_reader_core
// One-wire bus master that reads a temperature sensor. Each input item is one
// bus tick; each tick yields one result item with the bus drive level, status
// flags and, on the done tick, the scaled temperature (raw if not positive).
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | direction | role
//  --------+-----------------------------------------+-----------+-----------------------
//  s_      | s_valid s_ready s_cmd s_bus_in           | in        | one tick per item
//  m_      | m_valid m_ready m_bus_drive_low ...      | out       | one result per tick
//  cfg_    | cfg_valid cfg_ready cfg_index cfg_data   | in        | timing/offset registers
//
// Cycles: one item per clock while m_ takes results. The sequencer state and
//   the temperature scaling sit between the state registers and one result
//   register, so a tick's result appears on m_ in the cycle after acceptance.
// Reset: aresetn clears the sequencer to idle and loads the register defaults.
// Stalls: s_ready stays high while the result register is empty or is being
//   emptied this cycle; a stalled m_ side holds its item and stops s_.
// cfg_ready is always high; a write takes effect in the cycle after cfg_valid.
// ----------------------------------------------------------------------------
module one_wire_temperature_reader_core #(
    parameter int COUNTER_WIDTH = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_cmd,
    input  wire logic               s_bus_in,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_bus_drive_low,
    output logic                    m_busy_res,
    output logic                    m_done_res,
    output logic                    m_presence_fail,
    output logic signed [18:0]      m_temperature
);

    localparam int CW = COUNTER_WIDTH;
    localparam logic [32:0] CMAX = (33'd1 << CW) - 33'd1;

    // Clamp a 16-bit tick register into the counter range; optionally force
    // a floor of one tick.
    function automatic logic [CW-1:0] lim(input logic [15:0] r, input logic floor_one);
        logic [32:0] w;
        w = 33'(r);
        if (floor_one && (r == 16'd0)) begin
            w = 33'd1;
        end
        if (w > CMAX) begin
            w = CMAX;
        end
        return w[CW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] reset_low_reg, pres_tmo_reg, gap_reg, start_low_reg;
    logic [15:0] write_hold_reg, read_sample_reg, recovery_reg;
    logic [11:0] temp_offset_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reset_low_reg   <= owtr_pkg::RST_RESET_LOW;
            pres_tmo_reg    <= owtr_pkg::RST_PRES_TMO;
            gap_reg         <= owtr_pkg::RST_GAP;
            start_low_reg   <= owtr_pkg::RST_START_LOW;
            write_hold_reg  <= owtr_pkg::RST_WRITE_HOLD;
            read_sample_reg <= owtr_pkg::RST_READ_SAMPLE;
            recovery_reg    <= owtr_pkg::RST_RECOVERY;
            temp_offset_reg <= owtr_pkg::RST_TEMP_OFFSET;
        end else if (cfg_valid) begin
            case (owtr_pkg::reg_index_t'(cfg_index))
                owtr_pkg::REG_RESET_LOW:   reset_low_reg   <= cfg_data;
                owtr_pkg::REG_PRES_TMO:    pres_tmo_reg    <= cfg_data;
                owtr_pkg::REG_GAP:         gap_reg         <= cfg_data;
                owtr_pkg::REG_START_LOW:   start_low_reg   <= cfg_data;
                owtr_pkg::REG_WRITE_HOLD:  write_hold_reg  <= cfg_data;
                owtr_pkg::REG_READ_SAMPLE: read_sample_reg <= cfg_data;
                owtr_pkg::REG_RECOVERY:    recovery_reg    <= cfg_data;
                owtr_pkg::REG_TEMP_OFFSET: temp_offset_reg <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // Clamped tick limits
    logic [CW-1:0] n_reset, n_pres, n_gap_raw, n_gap, n_start, n_hold, n_samp, n_rec;
    assign n_reset   = lim(reset_low_reg, 1'b1);
    assign n_pres    = lim(pres_tmo_reg, 1'b1);
    assign n_gap_raw = lim(gap_reg, 1'b0);
    assign n_gap     = lim(gap_reg, 1'b1);
    assign n_start   = lim(start_low_reg, 1'b1);
    assign n_hold    = lim(write_hold_reg, 1'b1);
    assign n_samp    = lim(read_sample_reg, 1'b0);
    assign n_rec     = lim(recovery_reg, 1'b1);

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    owtr_pkg::phase_t phase_reg, phase_next, phase_cur;
    logic [CW-1:0]    tick_reg, tick_next, tick_cur, tick_inc;
    logic [2:0]       bit_reg, bit_next, bit_inc;
    logic [2:0]       byte_reg, byte_next, byte_cur, byte_inc;
    logic [7:0]       shift_reg, shift_next;
    logic [7:0]       low_reg, low_next;
    logic             fail_reg, fail_next, fail_cur;

    logic             drive, busy, done;
    logic signed [18:0] temp;

    // Handshake: the result register parts the two sides
    logic accept;
    logic m_valid_reg;
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Temperature scaling from the two read bytes
    logic signed [15:0] raw;
    logic [19:0]        prod;
    logic [19:0]        rounded;
    logic signed [18:0] scaled_temp;
    assign raw         = {shift_reg, low_reg};
    assign prod        = 20'(raw[14:0]) * owtr_pkg::TEMP_MUL;
    assign rounded     = (prod + owtr_pkg::TEMP_ROUND) >> 2;
    assign scaled_temp = signed'(rounded[18:0])
                       + signed'({{7{temp_offset_reg[11]}}, temp_offset_reg});

    assign tick_inc = tick_cur + {{(CW-1){1'b0}}, 1'b1};
    assign bit_inc  = bit_reg + 3'd1;
    assign byte_inc = byte_cur + 3'd1;

    always_comb begin
        // Start a measurement from idle
        phase_cur = phase_reg;
        tick_cur  = tick_reg;
        byte_cur  = byte_reg;
        fail_cur  = fail_reg;
        if ((phase_reg == owtr_pkg::PH_IDLE) && s_cmd) begin
            phase_cur = owtr_pkg::PH_RST;
            tick_cur  = '0;
            byte_cur  = 3'd0;
            fail_cur  = 1'b0;
        end

        phase_next = phase_cur;
        tick_next  = tick_cur;
        bit_next   = bit_reg;
        byte_next  = byte_cur;
        shift_next = shift_reg;
        low_next   = low_reg;
        fail_next  = fail_cur;
        drive      = 1'b0;
        busy       = 1'b1;
        done       = 1'b0;
        temp       = '0;

        case (phase_cur)
            owtr_pkg::PH_IDLE: begin
                busy = 1'b0;
            end
            owtr_pkg::PH_RST: begin
                drive     = 1'b1;
                tick_next = tick_inc;
                if (tick_inc >= n_reset) begin
                    phase_next = owtr_pkg::PH_PRES;
                    tick_next  = '0;
                end
            end
            owtr_pkg::PH_PRES: begin
                tick_next = tick_inc;
                if (!s_bus_in || (tick_inc >= n_pres)) begin
                    // presence seen or timed out: flag a timeout, go on
                    if (s_bus_in) begin
                        fail_next = 1'b1;
                    end
                    tick_next = '0;
                    if (n_gap_raw == '0) begin
                        bit_next   = 3'd0;
                        shift_next = owtr_pkg::cmd_byte(byte_cur);
                        phase_next = owtr_pkg::PH_WSTART;
                    end else begin
                        phase_next = owtr_pkg::PH_GAP;
                    end
                end
            end
            owtr_pkg::PH_GAP: begin
                tick_next = tick_inc;
                if (tick_inc >= n_gap) begin
                    tick_next  = '0;
                    bit_next   = 3'd0;
                    shift_next = owtr_pkg::cmd_byte(byte_cur);
                    phase_next = owtr_pkg::PH_WSTART;
                end
            end
            owtr_pkg::PH_WSTART, owtr_pkg::PH_RSTART: begin
                drive     = 1'b1;
                tick_next = tick_inc;
                if (tick_inc >= n_start) begin
                    tick_next  = '0;
                    phase_next = (phase_cur == owtr_pkg::PH_WSTART) ?
                                 owtr_pkg::PH_WHOLD : owtr_pkg::PH_RSAMP;
                end
            end
            owtr_pkg::PH_WHOLD: begin
                drive     = !shift_reg[0];
                tick_next = tick_inc;
                if (tick_inc >= n_hold) begin
                    tick_next  = '0;
                    phase_next = owtr_pkg::PH_WREC;
                end
            end
            owtr_pkg::PH_RSAMP: begin
                if (tick_cur >= n_samp) begin
                    // sample the bus into the top bit, LSB first
                    shift_next = {s_bus_in, shift_reg[7:1]};
                    tick_next  = '0;
                    phase_next = owtr_pkg::PH_RREC;
                end else begin
                    tick_next = tick_inc;
                end
            end
            owtr_pkg::PH_WREC, owtr_pkg::PH_RREC: begin
                tick_next = tick_inc;
                if (tick_inc >= n_rec) begin
                    // close the slot
                    if (phase_cur == owtr_pkg::PH_WREC) begin
                        shift_next = {1'b0, shift_reg[7:1]};
                    end
                    bit_next  = bit_inc;
                    tick_next = '0;
                    if (bit_inc != 3'd0) begin
                        phase_next = (byte_cur < owtr_pkg::BYTE_FIRST_READ) ?
                                     owtr_pkg::PH_WSTART : owtr_pkg::PH_RSTART;
                    end else if (byte_cur >= owtr_pkg::BYTE_LAST_READ) begin
                        if (phase_cur == owtr_pkg::PH_RREC) begin
                            // last read bit: emit the temperature
                            done       = 1'b1;
                            temp       = (!raw[15] && (raw != 16'sd0)) ? scaled_temp
                                                                       : 19'(raw);
                            phase_next = owtr_pkg::PH_IDLE;
                            bit_next   = 3'd0;
                            byte_next  = 3'd0;
                        end
                    end else begin
                        if (byte_cur == owtr_pkg::BYTE_FIRST_READ) begin
                            low_next = shift_reg;
                        end
                        byte_next = byte_inc;
                        if (byte_inc == owtr_pkg::BYTE_SECOND_RESET) begin
                            phase_next = owtr_pkg::PH_RST;
                        end else begin
                            bit_next   = 3'd0;
                            shift_next = owtr_pkg::cmd_byte(byte_inc);
                            phase_next = (byte_inc < owtr_pkg::BYTE_FIRST_READ) ?
                                         owtr_pkg::PH_WSTART : owtr_pkg::PH_RSTART;
                        end
                    end
                end
            end
            default: begin
                phase_next = owtr_pkg::PH_IDLE;
                tick_next  = '0;
                busy       = 1'b0;
            end
        endcase
    end

    // Advance the sequencer once per accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= owtr_pkg::PH_IDLE;
            tick_reg  <= '0;
            bit_reg   <= '0;
            byte_reg  <= '0;
            shift_reg <= '0;
            low_reg   <= '0;
            fail_reg  <= 1'b0;
        end else if (accept) begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            byte_reg  <= byte_next;
            shift_reg <= shift_next;
            low_reg   <= low_next;
            fail_reg  <= fail_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register: load on accept, hold while m_ stalls
    // ------------------------------------------------------------------
    logic               drive_reg, busy_reg, done_reg, pfail_reg;
    logic signed [18:0] temp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            drive_reg <= drive;
            busy_reg  <= busy;
            done_reg  <= done;
            pfail_reg <= fail_next;
            temp_reg  <= temp;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_bus_drive_low = drive_reg;
    assign m_busy_res      = busy_reg;
    assign m_done_res      = done_reg;
    assign m_presence_fail = pfail_reg;
    assign m_temperature   = temp_reg;

endmodule
`default_nettype wire

### test/tb_one_wire_temperature_reader_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_one_wire_temperature_reader_core
// Self-checking bench for the one-wire temperature reader. Bus ticks are
// queued as whole measurement sequences and then driven with random gaps.
// A tick-by-tick model of the bus master predicts each result item, and a
// monitor compares every result field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_one_wire_temperature_reader_core;

    localparam int STALL_LIMIT   = 2000;  // idle cycles before the watchdog trips
    localparam int SQUEEZE_AT    = 600;   // result count that triggers the long hold
    localparam int SQUEEZE_LEN   = 300;   // cycles the receiver holds off
    localparam int TOTAL_TICKS   = 1950;  // bus ticks in the whole run
    localparam int CLOSING_TICKS = 350;   // room kept for the closing stretch

    // One bus tick as presented on the input channel
    typedef struct packed {
        logic cmd;
        logic bus;
    } bus_tick_t;

    // One result item as seen on the output channel
    typedef struct packed {
        logic        drive_low;
        logic        busy;
        logic        done;
        logic        presence_fail;
        logic [18:0] temperature;
    } reading_t;

    logic                 aclk;
    logic                 aresetn    = 1'b0;
    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    owtr_pkg::reg_index_t cfg_index  = owtr_pkg::REG_RESET_LOW;
    logic [15:0]          cfg_data   = '0;
    logic                 s_valid    = 1'b0;
    logic                 s_ready;
    logic                 s_cmd      = 1'b0;
    logic                 s_bus_in   = 1'b1;
    logic                 m_valid;
    logic                 m_ready    = 1'b0;
    logic                 m_bus_drive_low;
    logic                 m_busy_res;
    logic                 m_done_res;
    logic                 m_presence_fail;
    logic signed [18:0]   m_temperature;

    one_wire_temperature_reader_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_bus_in        (s_bus_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_bus_drive_low (m_bus_drive_low),
        .m_busy_res      (m_busy_res),
        .m_done_res      (m_done_res),
        .m_presence_fail (m_presence_fail),
        .m_temperature   (m_temperature)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Bus master model. Register copies follow the values written on the
    // configuration channel; sequencer state advances once per accepted tick.
    // ------------------------------------------------------------------------
    logic [15:0]      reg_value [8];
    owtr_pkg::phase_t seq_phase  = owtr_pkg::PH_IDLE;
    logic [15:0]      tick_cnt   = '0;
    logic [2:0]       bit_pos    = '0;
    logic [2:0]       byte_pos   = '0;
    logic [7:0]       shifter    = '0;
    logic [7:0]       low_q      = '0;
    logic             fail_flag  = 1'b0;

    // Timing registers below one behave as one
    function automatic logic [15:0] floor_one(input logic [15:0] n);
        return (n == 16'd0) ? 16'd1 : n;
    endfunction

    // Advance the phase counter; true once the phase has lasted n ticks
    function automatic logic count_to(input logic [15:0] n);
        tick_cnt = tick_cnt + 16'd1;
        return tick_cnt >= floor_one(n);
    endfunction

    // Open the next bit slot: write slots for command bytes, read slots after
    function automatic void open_slot();
        tick_cnt  = '0;
        seq_phase = (byte_pos < owtr_pkg::BYTE_FIRST_READ) ? owtr_pkg::PH_WSTART
                                                           : owtr_pkg::PH_RSTART;
    endfunction

    function automatic void load_byte();
        bit_pos = '0;
        case (byte_pos)
            3'd0, 3'd2: shifter = owtr_pkg::CMD_SKIP_ROM;
            3'd1:       shifter = owtr_pkg::CMD_CONVERT;
            3'd3:       shifter = owtr_pkg::CMD_READ_SCRATCH;
            default:    shifter = 8'h00;
        endcase
        open_slot();
    endfunction

    // Presence wait is over: run the gap, or go straight to the first byte
    function automatic void enter_gap();
        tick_cnt = '0;
        if (reg_value[owtr_pkg::REG_GAP] == 16'd0)
            load_byte();
        else
            seq_phase = owtr_pkg::PH_GAP;
    endfunction

    // Close a slot; true once the last bit of the second read byte is in
    function automatic logic close_slot();
        bit_pos = bit_pos + 3'd1;
        if (bit_pos != 3'd0) begin
            open_slot();
            return 1'b0;
        end
        if (byte_pos >= owtr_pkg::BYTE_LAST_READ)
            return 1'b1;
        if (byte_pos == owtr_pkg::BYTE_FIRST_READ)
            low_q = shifter;
        byte_pos = byte_pos + 3'd1;
        if (byte_pos == owtr_pkg::BYTE_SECOND_RESET) begin
            seq_phase = owtr_pkg::PH_RST;
            tick_cnt  = '0;
        end else begin
            load_byte();
        end
        return 1'b0;
    endfunction

    function automatic reading_t step_reader(input logic cmd, input logic bus);
        reading_t           r;
        logic signed [15:0] raw16;
        logic signed [11:0] off12;
        int                 temp;
        r      = '0;
        r.busy = 1'b1;
        // a start is only honored while idle; the start tick is the first reset tick
        if (seq_phase == owtr_pkg::PH_IDLE && cmd) begin
            fail_flag = 1'b0;
            byte_pos  = '0;
            tick_cnt  = '0;
            seq_phase = owtr_pkg::PH_RST;
        end
        case (seq_phase)
            owtr_pkg::PH_IDLE: r.busy = 1'b0;
            owtr_pkg::PH_RST: begin
                r.drive_low = 1'b1;
                if (count_to(reg_value[owtr_pkg::REG_RESET_LOW])) begin
                    seq_phase = owtr_pkg::PH_PRES;
                    tick_cnt  = '0;
                end
            end
            owtr_pkg::PH_PRES: begin
                if (!bus) begin
                    enter_gap();
                end else if (count_to(reg_value[owtr_pkg::REG_PRES_TMO])) begin
                    fail_flag = 1'b1;
                    enter_gap();
                end
            end
            owtr_pkg::PH_GAP: begin
                if (count_to(reg_value[owtr_pkg::REG_GAP]))
                    load_byte();
            end
            owtr_pkg::PH_WSTART: begin
                r.drive_low = 1'b1;
                if (count_to(reg_value[owtr_pkg::REG_START_LOW])) begin
                    seq_phase = owtr_pkg::PH_WHOLD;
                    tick_cnt  = '0;
                end
            end
            owtr_pkg::PH_WHOLD: begin
                r.drive_low = ~shifter[0];
                if (count_to(reg_value[owtr_pkg::REG_WRITE_HOLD])) begin
                    seq_phase = owtr_pkg::PH_WREC;
                    tick_cnt  = '0;
                end
            end
            owtr_pkg::PH_WREC: begin
                if (count_to(reg_value[owtr_pkg::REG_RECOVERY])) begin
                    shifter = shifter >> 1;
                    void'(close_slot());
                end
            end
            owtr_pkg::PH_RSTART: begin
                r.drive_low = 1'b1;
                if (count_to(reg_value[owtr_pkg::REG_START_LOW])) begin
                    seq_phase = owtr_pkg::PH_RSAMP;
                    tick_cnt  = '0;
                end
            end
            owtr_pkg::PH_RSAMP: begin
                // sample on the tick after the released wait; that tick is released too
                if (tick_cnt >= reg_value[owtr_pkg::REG_READ_SAMPLE]) begin
                    shifter   = {bus, shifter[7:1]};
                    seq_phase = owtr_pkg::PH_RREC;
                    tick_cnt  = '0;
                end else begin
                    tick_cnt = tick_cnt + 16'd1;
                end
            end
            owtr_pkg::PH_RREC: begin
                if (count_to(reg_value[owtr_pkg::REG_RECOVERY])) begin
                    if (close_slot()) begin
                        raw16 = {shifter, low_q};
                        off12 = reg_value[owtr_pkg::REG_TEMP_OFFSET][11:0];
                        // raw * 6.25 hundredths, rounded half up, then the offset
                        if (raw16 > 0)
                            temp = ((int'(raw16) * 25 + 2) >>> 2) + int'(off12);
                        else
                            temp = int'(raw16);
                        r.temperature = temp[18:0];
                        r.done        = 1'b1;
                        seq_phase     = owtr_pkg::PH_IDLE;
                        tick_cnt      = '0;
                        bit_pos       = '0;
                        byte_pos      = '0;
                    end
                end
            end
            default: begin
                seq_phase = owtr_pkg::PH_IDLE;
                tick_cnt  = '0;
                r.busy    = 1'b0;
            end
        endcase
        r.presence_fail = fail_flag;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Tick source: the stimulus process fills ticks_pending, the driver below
    // drains it onto s_ and feeds every accepted tick to the model.
    // ------------------------------------------------------------------------
    bus_tick_t ticks_pending [$];
    reading_t  readings_due [$];
    int        ticks_queued  = 0;
    int        ticks_taken   = 0;
    int        results_seen  = 0;
    int        mismatches    = 0;
    int        src_idle      = 0;
    int        sink_hold     = 0;
    int        quiet_cycles  = 0;
    logic      calm          = 1'b0;   // no idling on either side when set
    logic      squeezed      = 1'b0;
    bus_tick_t next_tick;
    reading_t  want;
    reading_t  got;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                readings_due.push_back(step_reader(s_cmd, s_bus_in));
                ticks_taken++;
            end
            // hold the current tick until it is taken
            if (!s_valid || s_ready) begin
                if (src_idle > 0) begin
                    src_idle--;
                    s_valid <= 1'b0;
                end else if (ticks_pending.size() > 0) begin
                    // idle only in every other stretch of 256 ticks
                    if (!calm && ticks_taken[8] && $urandom_range(0, 11) == 0) begin
                        src_idle = $urandom_range(1, 10) - 1;
                        s_valid <= 1'b0;
                    end else begin
                        next_tick = ticks_pending.pop_front();
                        s_valid  <= 1'b1;
                        s_cmd    <= next_tick.cmd;
                        s_bus_in <= next_tick.bus;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor and receiver stalls
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                got = {m_bus_drive_low, m_busy_res, m_done_res, m_presence_fail,
                       m_temperature};
                if (readings_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with nothing expected", results_seen);
                end else begin
                    want = readings_due.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("result %0d: expected drive=%b busy=%b done=%b ",
                                   results_seen, want.drive_low, want.busy, want.done);
                            $write("fail=%b temp=%0d, ",
                                   want.presence_fail, $signed(want.temperature));
                            $display("got drive=%b busy=%b done=%b fail=%b temp=%0d",
                                     got.drive_low, got.busy, got.done,
                                     got.presence_fail, $signed(got.temperature));
                        end
                    end
                end
            end
            // one long hold-off so the block fills up and stalls its input
            if (!squeezed && results_seen >= SQUEEZE_AT) begin
                squeezed  = 1'b1;
                sink_hold = SQUEEZE_LEN;
            end
            if (sink_hold > 0) begin
                sink_hold--;
                m_ready <= 1'b0;
            end else if (!calm && !results_seen[8] && $urandom_range(0, 9) == 0) begin
                sink_hold = $urandom_range(1, 10) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when nothing moves on any channel for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_one_wire_temperature_reader_core failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_tick(input logic cmd, input logic bus);
        ticks_pending.push_back('{cmd: cmd, bus: bus});
        ticks_queued++;
    endtask

    // Random bus level; a random start only when the sequencer is busy anyway
    task automatic push_noise(input int n, input logic may_start);
        repeat (n)
            push_tick(may_start ? 1'($urandom_range(0, 1)) : 1'b0, 1'($urandom_range(0, 1)));
    endtask

    // Queue one full measurement under the current register values. The read
    // slots return raw least significant bit first; a set bit in no_presence
    // keeps the bus high through that reset's whole presence wait (timeout <= 16).
    task automatic queue_reading(input logic [15:0] raw, input logic [1:0] no_presence);
        int rl, tmo, gp, sl, wh, rs, rc, k;
        rl  = floor_one(reg_value[owtr_pkg::REG_RESET_LOW]);
        tmo = floor_one(reg_value[owtr_pkg::REG_PRES_TMO]);
        gp  = reg_value[owtr_pkg::REG_GAP];
        sl  = floor_one(reg_value[owtr_pkg::REG_START_LOW]);
        wh  = floor_one(reg_value[owtr_pkg::REG_WRITE_HOLD]);
        rs  = reg_value[owtr_pkg::REG_READ_SAMPLE];
        rc  = floor_one(reg_value[owtr_pkg::REG_RECOVERY]);
        if (tmo > 16)
            no_presence = 2'b00;
        push_tick(1'b1, 1'($urandom_range(0, 1)));
        push_noise(rl - 1, 1'b1);
        for (int half = 0; half < 2; half++) begin
            if (half == 1)
                push_noise(rl, 1'b1);
            if (no_presence[half]) begin
                repeat (tmo) push_tick(1'($urandom_range(0, 1)), 1'b1);
            end else begin
                k = $urandom_range(1, (tmo < 6) ? tmo : 6);
                repeat (k - 1) push_tick(1'($urandom_range(0, 1)), 1'b1);
                push_tick(1'($urandom_range(0, 1)), 1'b0);
            end
            push_noise(gp, 1'b1);
            // two command bytes of write slots
            push_noise(16 * (sl + wh + rc), 1'b1);
        end
        for (int b = 0; b < 16; b++) begin
            push_noise(sl + rs, 1'b1);
            push_tick(1'($urandom_range(0, 1)), raw[b]);
            push_noise(rc, 1'b1);
        end
        push_noise($urandom_range(1, 4), 1'b0);
    endtask

    // Wait until every queued tick is taken and every result has come back
    task automatic drain();
        while (ticks_pending.size() != 0 || s_valid || readings_due.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input owtr_pkg::reg_index_t idx, input logic [15:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        reg_value[idx] = data;
        cfg_valid <= 1'b0;
    endtask

    task automatic set_timing(input logic [15:0] rl, input logic [15:0] tmo,
                              input logic [15:0] gp, input logic [15:0] sl,
                              input logic [15:0] wh, input logic [15:0] rs,
                              input logic [15:0] rc);
        drain();
        write_reg(owtr_pkg::REG_RESET_LOW, rl);
        write_reg(owtr_pkg::REG_PRES_TMO, tmo);
        write_reg(owtr_pkg::REG_GAP, gp);
        write_reg(owtr_pkg::REG_START_LOW, sl);
        write_reg(owtr_pkg::REG_WRITE_HOLD, wh);
        write_reg(owtr_pkg::REG_READ_SAMPLE, rs);
        write_reg(owtr_pkg::REG_RECOVERY, rc);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int n_reads;
        reg_value[owtr_pkg::REG_RESET_LOW]   = 16'd480;
        reg_value[owtr_pkg::REG_PRES_TMO]    = 16'd5000;
        reg_value[owtr_pkg::REG_GAP]         = 16'd1000;
        reg_value[owtr_pkg::REG_START_LOW]   = 16'd1;
        reg_value[owtr_pkg::REG_WRITE_HOLD]  = 16'd68;
        reg_value[owtr_pkg::REG_READ_SAMPLE] = 16'd6;
        reg_value[owtr_pkg::REG_RECOVERY]    = 16'd48;
        reg_value[owtr_pkg::REG_TEMP_OFFSET] = 16'd750;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // All timings zero: the gap is skipped and every other phase lasts one
        // tick. The offset keeps its reset value here.
        set_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        queue_reading(16'h0001, 2'b00);
        queue_reading(16'h0000, 2'b01);     // first reset sees no presence
        push_noise(3, 1'b0);                 // presence fail holds while idle

        // Largest presence timeout, largest positive offset and raw value
        set_timing(16'd3, 16'hFFFF, 16'd2, 16'd2, 16'd2, 16'd3, 16'd2);
        write_reg(owtr_pkg::REG_TEMP_OFFSET, 16'h07FF);
        queue_reading(16'h7FFF, 2'b00);

        // Most negative offset, upper data bits set; most negative raw value,
        // both resets without presence; then minus one, then five
        set_timing(16'd1, 16'd2, 16'd1, 16'd1, 16'd1, 16'd0, 16'd1);
        write_reg(owtr_pkg::REG_TEMP_OFFSET, 16'hF800);
        queue_reading(16'h8000, 2'b11);
        queue_reading(16'hFFFF, 2'b10);
        queue_reading(16'h0005, 2'b00);

        // Random phases: mostly the shortest timings, so that many complete
        // measurements fit; now and then somewhat longer slots.
        while (ticks_queued < TOTAL_TICKS - CLOSING_TICKS) begin
            if ($urandom_range(0, 3) != 0)
                set_timing(16'($urandom_range(0, 1)), 16'($urandom_range(1, 3)),
                           16'($urandom_range(0, 1)), 16'($urandom_range(0, 1)),
                           16'($urandom_range(0, 1)), 16'd0,
                           16'($urandom_range(0, 1)));
            else
                set_timing(16'($urandom_range(1, 4)), 16'($urandom_range(1, 8)),
                           16'($urandom_range(0, 3)), 16'($urandom_range(1, 2)),
                           16'($urandom_range(1, 3)), 16'($urandom_range(0, 3)),
                           16'($urandom_range(1, 3)));
            write_reg(owtr_pkg::REG_TEMP_OFFSET, 16'($urandom));
            n_reads = $urandom_range(1, 2);
            repeat (n_reads) begin
                if ($urandom_range(0, 3) == 0)
                    queue_reading(16'($urandom_range(0, 20)),
                                  {1'($urandom_range(0, 3) == 0),
                                   1'($urandom_range(0, 3) == 0)});
                else
                    queue_reading(16'($urandom),
                                  {1'($urandom_range(0, 3) == 0),
                                   1'($urandom_range(0, 3) == 0)});
            end
        end

        // Closing stretch with both sides running flat out
        set_timing(16'd1, 16'd2, 16'd0, 16'd1, 16'd1, 16'd1, 16'd1);
        calm = 1'b1;
        write_reg(owtr_pkg::REG_TEMP_OFFSET, 16'($urandom));
        queue_reading(16'($urandom), 2'b00);
        queue_reading(16'($urandom), 2'b00);

        drain();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("tb_one_wire_temperature_reader_core passed");
        else
            $display("tb_one_wire_temperature_reader_core failed");
        $finish;
    end

endmodule
`default_nettype wire
